// ===== hdl/vbfe_pkg.sv =====
// vbfe_pkg: shared types and constants of the voxel boundary face extractor.
// Used by vbfe_front, vbfe_queue, vbfe_back and voxel_boundary_face_extract_top.
package vbfe_pkg;

  localparam int unsigned MAX_ROW    = 256;
  localparam int unsigned MAX_COL    = 256;
  localparam int unsigned MAX_SLICES = 1024;

  localparam int unsigned X_W     = 8;   // x coordinate
  localparam int unsigned Y_W     = 8;   // y coordinate
  localparam int unsigned Z_W     = 10;  // z coordinate
  localparam int unsigned ROW_W   = 9;   // row_size / col_size register
  localparam int unsigned SLC_W   = 11;  // slice_count register
  localparam int unsigned VOX_W   = 8;
  localparam int unsigned ADDR_W  = X_W + Y_W;
  localparam int unsigned MEM_DEPTH = MAX_ROW * MAX_COL;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [ROW_W-1:0] ROW_MIN = ROW_W'(2);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROW);
  localparam logic [ROW_W-1:0] COL_MAX = ROW_W'(MAX_COL);
  localparam logic [SLC_W-1:0] SLC_MIN = SLC_W'(2);
  localparam logic [SLC_W-1:0] SLC_MAX = SLC_W'(MAX_SLICES);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_ROW_SIZE    = 2'd1,
    REG_COL_SIZE    = 2'd2,
    REG_SLICE_COUNT = 2'd3
  } reg_idx_e;

  typedef enum logic {
    FR_OPEN   = 1'b0,  // accepting; first pair of neighbor reads
    FR_SECOND = 1'b1   // reading the +y neighbor
  } front_state_e;

  // effective (clamped) configuration
  typedef struct packed {
    logic [VOX_W-1:0] level;
    logic [ROW_W-1:0] row_len;
    logic [ROW_W-1:0] col_len;
    logic [SLC_W-1:0] slices;
  } cfg_t;

  // one classified voxel: up to three faces, bit 0 +x, bit 1 +y, bit 2 +z
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    logic [2:0]     mask;
    logic           base;
  } face_entry_t;

endpackage

// ===== hdl/voxel_boundary_face_extract_top.sv =====
// Voxel boundary face extractor: APB registers, front, queue and back.
// Depends on vbfe_pkg, vbfe_front, vbfe_queue, vbfe_back.
//
// Voxels enter on voxel_i (valid/stall) in raster order, x fastest, then y,
// then z. Each is classed object when at or above the threshold (0 acts as 1).
// For base voxel (i,j,k) the block emits one face request per differing
// +x, +y, +z neighbor once voxel (i,j,k+1) arrives, in that order, with
// last_o set on the final face of that voxel.
// The front takes no new voxel while it reads the +y neighbor, as the
// previous-slice bit memory has two read ports for three neighbors.
// The back emits one face per cycle while face_stall_i is low.
// The first face of a voxel passes the neighbor reads, the queue and the
// output register before it shows on face_valid_o. A 4-entry queue lets
// the front run on while face_stall_i holds the output; when it is full,
// a voxel with faces raises voxel_stall_o. No face is dropped or reordered.
// Reset clears counters, queue and output; slice bits stay undefined until
// written, and registers return to threshold 0 and sizes 256, 256, 1024.
// Registers (APB, byte address 4*i): threshold, row_size, col_size,
// slice_count. Write them only while the block is idle.
module voxel_boundary_face_extract_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        voxel_valid_i,
  output logic                        voxel_stall_o,
  input  logic [vbfe_pkg::VOX_W-1:0]  voxel_i,
  output logic                        face_valid_o,
  input  logic                        face_stall_i,
  output logic [vbfe_pkg::X_W-1:0]    face_x_o,
  output logic [vbfe_pkg::Y_W-1:0]    face_y_o,
  output logic [vbfe_pkg::Z_W-1:0]    face_z_o,
  output logic [1:0]                  axis_o,
  output logic                        base_inside_o,
  output logic                        last_o
);

  logic [vbfe_pkg::VOX_W-1:0] thr_q;
  logic [vbfe_pkg::ROW_W-1:0] row_q, col_q;
  logic [vbfe_pkg::SLC_W-1:0] slc_q;
  logic wr_en;
  vbfe_pkg::reg_idx_e idx;
  vbfe_pkg::cfg_t cfg;

  vbfe_pkg::face_entry_t q_in, q_head;
  logic q_push, q_full, q_pop, q_empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = vbfe_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (idx)
      vbfe_pkg::REG_THRESHOLD:   prdata = {24'd0, thr_q};
      vbfe_pkg::REG_ROW_SIZE:    prdata = {23'd0, row_q};
      vbfe_pkg::REG_COL_SIZE:    prdata = {23'd0, col_q};
      vbfe_pkg::REG_SLICE_COUNT: prdata = {21'd0, slc_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      row_q <= vbfe_pkg::ROW_MAX;
      col_q <= vbfe_pkg::COL_MAX;
      slc_q <= vbfe_pkg::SLC_MAX;
    end else if (wr_en) begin
      unique case (idx)
        vbfe_pkg::REG_THRESHOLD:   thr_q <= pwdata[vbfe_pkg::VOX_W-1:0];
        vbfe_pkg::REG_ROW_SIZE:    row_q <= pwdata[vbfe_pkg::ROW_W-1:0];
        vbfe_pkg::REG_COL_SIZE:    col_q <= pwdata[vbfe_pkg::ROW_W-1:0];
        vbfe_pkg::REG_SLICE_COUNT: slc_q <= pwdata[vbfe_pkg::SLC_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes clamped to the supported range, zero threshold reads as one
  assign cfg.level   = (thr_q == '0) ? vbfe_pkg::VOX_W'(1) : thr_q;
  assign cfg.row_len = (row_q < vbfe_pkg::ROW_MIN) ? vbfe_pkg::ROW_MIN :
                       (row_q > vbfe_pkg::ROW_MAX) ? vbfe_pkg::ROW_MAX : row_q;
  assign cfg.col_len = (col_q < vbfe_pkg::ROW_MIN) ? vbfe_pkg::ROW_MIN :
                       (col_q > vbfe_pkg::COL_MAX) ? vbfe_pkg::COL_MAX : col_q;
  assign cfg.slices  = (slc_q < vbfe_pkg::SLC_MIN) ? vbfe_pkg::SLC_MIN :
                       (slc_q > vbfe_pkg::SLC_MAX) ? vbfe_pkg::SLC_MAX : slc_q;

  vbfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .voxel_valid_i (voxel_valid_i),
    .voxel_stall_o (voxel_stall_o),
    .voxel_i       (voxel_i),
    .push_o        (q_push),
    .entry_o       (q_in),
    .full_i        (q_full)
  );

  vbfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  vbfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .face_valid_o  (face_valid_o),
    .face_stall_i  (face_stall_i),
    .face_x_o      (face_x_o),
    .face_y_o      (face_y_o),
    .face_z_o      (face_z_o),
    .axis_o        (axis_o),
    .base_inside_o (base_inside_o),
    .last_o        (last_o)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("face queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("face queue underflow");

  a_two_cycle_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (voxel_valid_i && !voxel_stall_o) |=> voxel_stall_o)
    else $error("voxel accepted during second read cycle");

  a_faces_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (face_valid_o && !face_stall_i && !last_o) |=> face_valid_o)
    else $error("faces of a voxel cut short");
`endif

endmodule

// ===== hdl/vbfe_front.sv =====
// vbfe_front: counters, class-bit slice memories and neighbor classification.
// Pushes one face_entry_t per voxel that has faces. Depends on vbfe_pkg.
module vbfe_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vbfe_pkg::cfg_t              cfg_i,
  input  logic                        voxel_valid_i,
  output logic                        voxel_stall_o,
  input  logic [vbfe_pkg::VOX_W-1:0]  voxel_i,
  output logic                        push_o,
  output vbfe_pkg::face_entry_t       entry_o,
  input  logic                        full_i
);

  vbfe_pkg::front_state_e state_q, state_d;
  logic pend_q, pend_d;
  logic bank_q, bank_d;
  logic [vbfe_pkg::X_W-1:0] x_q, x_d;
  logic [vbfe_pkg::Y_W-1:0] y_q, y_d;
  logic [vbfe_pkg::Z_W-1:0] z_q, z_d;

  // item being classified
  logic [vbfe_pkg::X_W-1:0] it_x_q;
  logic [vbfe_pkg::Y_W-1:0] it_y_q;
  logic [vbfe_pkg::Z_W-1:0] it_z_q;
  logic it_live_q, it_inside_q, it_bank_q;

  logic bank0 [vbfe_pkg::MEM_DEPTH];
  logic bank1 [vbfe_pkg::MEM_DEPTH];
  logic r0_b0_q, r0_b1_q, r1_b0_q, r1_b1_q, nbx_q;

  logic accept, done, is_obj, live, x_last, y_last, z_last, rd1_en;
  logic base, nby;
  logic [2:0] mask;
  logic [vbfe_pkg::ADDR_W-1:0] wa, ra0, ra1;

  assign is_obj = voxel_i >= cfg_i.level;
  assign x_last = ({1'b0, x_q} + vbfe_pkg::ROW_W'(1)) >= cfg_i.row_len;
  assign y_last = ({1'b0, y_q} + vbfe_pkg::ROW_W'(1)) >= cfg_i.col_len;
  assign z_last = ({1'b0, z_q} + vbfe_pkg::SLC_W'(1)) >= cfg_i.slices;
  assign live   = (z_q != '0) && !x_last && !y_last;

  // classification of the pending item
  assign base = it_bank_q ? r0_b1_q : r0_b0_q;
  assign nby  = it_bank_q ? r1_b1_q : r1_b0_q;
  assign mask = it_live_q ? {it_inside_q != base, nby != base, nbx_q != base} : 3'b000;

  assign done   = pend_q && ((mask == 3'b000) || !full_i);
  assign accept = voxel_valid_i && (state_q == vbfe_pkg::FR_OPEN) && (!pend_q || done);
  assign voxel_stall_o = !((state_q == vbfe_pkg::FR_OPEN) && (!pend_q || done));
  assign push_o = pend_q && !full_i && (mask != 3'b000);

  assign entry_o.x    = it_x_q;
  assign entry_o.y    = it_y_q;
  assign entry_o.z    = it_z_q - vbfe_pkg::Z_W'(1);
  assign entry_o.mask = mask;
  assign entry_o.base = base;

  // address = y * MAX_ROW + x, MAX_ROW being a power of two
  assign wa     = {y_q, x_q};
  assign ra0    = {y_q, x_q};
  assign ra1    = (state_q == vbfe_pkg::FR_OPEN) ? {y_q, x_q + vbfe_pkg::X_W'(1)}
                                                 : {it_y_q + vbfe_pkg::Y_W'(1), it_x_q};
  assign rd1_en = accept || (state_q == vbfe_pkg::FR_SECOND);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    bank_d  = bank_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    unique case (state_q)
      vbfe_pkg::FR_OPEN: begin
        if (done) pend_d = 1'b0;
        if (accept) begin
          state_d = vbfe_pkg::FR_SECOND;
          if (x_last) begin
            x_d = '0;
            if (y_last) begin
              y_d = '0;
              bank_d = !bank_q;  // current slice becomes previous
              z_d = z_last ? '0 : z_q + vbfe_pkg::Z_W'(1);
            end else begin
              y_d = y_q + vbfe_pkg::Y_W'(1);
            end
          end else begin
            x_d = x_q + vbfe_pkg::X_W'(1);
          end
        end
      end
      vbfe_pkg::FR_SECOND: begin
        state_d = vbfe_pkg::FR_OPEN;
        pend_d  = 1'b1;
      end
      default: state_d = vbfe_pkg::FR_OPEN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vbfe_pkg::FR_OPEN;
      pend_q  <= 1'b0;
      bank_q  <= 1'b0;
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      bank_q  <= bank_d;
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_x_q      <= x_q;
      it_y_q      <= y_q;
      it_z_q      <= z_q;
      it_live_q   <= live;
      it_inside_q <= is_obj;
      it_bank_q   <= !bank_q;
    end
    if (state_q == vbfe_pkg::FR_SECOND) nbx_q <= it_bank_q ? r1_b1_q : r1_b0_q;
  end

  // slice memories: written in the current bank, read in the previous one
  always_ff @(posedge clk_i) begin
    if (accept && !bank_q) bank0[wa] <= is_obj;
    if (accept) begin
      r0_b0_q <= bank0[ra0];
    end
    if (rd1_en) r1_b0_q <= bank0[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (accept && bank_q) bank1[wa] <= is_obj;
    if (accept) begin
      r0_b1_q <= bank1[ra0];
    end
    if (rd1_en) r1_b1_q <= bank1[ra1];
  end

endmodule

// ===== hdl/vbfe_queue.sv =====
// vbfe_queue: small FIFO of classified voxels between front and back.
// Depends on vbfe_pkg.
module vbfe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  vbfe_pkg::face_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output vbfe_pkg::face_entry_t head_o,
  output logic                  empty_o
);

  vbfe_pkg::face_entry_t slots_q [vbfe_pkg::QUEUE_DEPTH];
  logic [vbfe_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [vbfe_pkg::QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == vbfe_pkg::QCNT_W'(vbfe_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + vbfe_pkg::QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + vbfe_pkg::QPTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + vbfe_pkg::QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - vbfe_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= entry_i;
  end

endmodule

// ===== hdl/vbfe_back.sv =====
// vbfe_back: expands one classified voxel into face requests, one per cycle
// unless stalled. Holds the entry in an output register. Depends on vbfe_pkg.
module vbfe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vbfe_pkg::face_entry_t       head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        face_valid_o,
  input  logic                        face_stall_i,
  output logic [vbfe_pkg::X_W-1:0]    face_x_o,
  output logic [vbfe_pkg::Y_W-1:0]    face_y_o,
  output logic [vbfe_pkg::Z_W-1:0]    face_z_o,
  output logic [1:0]                  axis_o,
  output logic                        base_inside_o,
  output logic                        last_o
);

  vbfe_pkg::face_entry_t cur_q;
  logic cur_valid_q;
  logic take;
  logic [2:0] low, rest;
  vbfe_pkg::axis_e axis;

  // lowest pending face goes first: +x, then +y, then +z
  always_comb begin
    if (cur_q.mask[0]) begin
      low  = 3'b001;
      axis = vbfe_pkg::AXIS_X;
    end else if (cur_q.mask[1]) begin
      low  = 3'b010;
      axis = vbfe_pkg::AXIS_Y;
    end else begin
      low  = 3'b100;
      axis = vbfe_pkg::AXIS_Z;
    end
  end

  assign rest  = cur_q.mask & ~low;
  assign take  = cur_valid_q && !face_stall_i;
  assign pop_o = (!cur_valid_q || (take && (rest == 3'b000))) && !empty_i;

  assign face_valid_o  = cur_valid_q;
  assign face_x_o      = cur_q.x;
  assign face_y_o      = cur_q.y;
  assign face_z_o      = cur_q.z;
  assign axis_o        = axis;
  assign base_inside_o = cur_q.base;
  assign last_o        = rest == 3'b000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
    end else if (take && (rest == 3'b000)) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end else if (take) begin
      cur_q.mask <= rest;
    end
  end

endmodule

// ===== bench/tb_voxel_boundary_face_extract_top.sv =====
// tb_voxel_boundary_face_extract_top: self-checking bench for the voxel boundary face extractor.
// Depends on vbfe_pkg and voxel_boundary_face_extract_top. Keeps its own copy of the slice
// class bits, predicts the face requests of every accepted voxel and checks them in order.
module tb_voxel_boundary_face_extract_top;
  import vbfe_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_VOXELS  = 110;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    axis_e          dir;
    logic           base_in;
    logic           tail;
  } face_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             voxel_valid_i = 1'b0;
  logic             voxel_stall_o;
  logic [VOX_W-1:0] voxel_i = '0;
  logic             face_valid_o;
  logic             face_stall_i = 1'b0;
  logic [X_W-1:0]   face_x_o;
  logic [Y_W-1:0]   face_y_o;
  logic [Z_W-1:0]   face_z_o;
  logic [1:0]       axis_o;
  logic             base_inside_o;
  logic             last_o;

  voxel_boundary_face_extract_top dut (.*);

  // register copies and predicted block state
  logic [VOX_W-1:0] lvl_reg = '0;
  logic [ROW_W-1:0] row_reg = ROW_W'(MAX_ROW);
  logic [ROW_W-1:0] col_reg = ROW_W'(MAX_COL);
  logic [SLC_W-1:0] slc_reg = SLC_W'(MAX_SLICES);
  bit               prev_bits [MAX_COL][MAX_ROW];
  bit               cur_bits [MAX_COL][MAX_ROW];
  int unsigned      pos_x = 0;
  int unsigned      pos_y = 0;
  int unsigned      pos_z = 0;

  face_t            faces_due[$];
  logic [VOX_W-1:0] voxel_feed[$];
  int               bad_faces = 0;
  bit               voxel_taken = 1'b0;
  int               gap_left = 0;
  int               stall_left = 0;
  int               hold_left = 0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  bit               calm = 1'b0;
  int               calm_cnt = 0;
  int               idle_cycles = 0;

  function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void eff_sizes(output int unsigned rs, cs, ds);
    rs = clamp_len(row_reg, MAX_ROW);
    cs = clamp_len(col_reg, MAX_COL);
    ds = clamp_len(slc_reg, MAX_SLICES);
  endfunction

  function automatic void next_pos(input int unsigned rs, cs, ds,
                                   inout int unsigned x, y, z, output bit slice_end);
    slice_end = 1'b0;
    if (x + 1 >= rs) begin
      x = 0;
      if (y + 1 >= cs) begin
        y = 0;
        slice_end = 1'b1;
        z = (z + 1 >= ds) ? 0 : z + 1;
      end else begin
        y++;
      end
    end else begin
      x++;
    end
  endfunction

  // faces caused by one voxel: base one slice below, +x, +y, +z in that order
  function automatic void extract_faces(logic [VOX_W-1:0] v);
    int unsigned rs, cs, ds, lvl;
    bit          obj, base, slice_end;
    face_t       f;
    face_t       found[$];
    eff_sizes(rs, cs, ds);
    lvl = (lvl_reg == 0) ? 1 : lvl_reg;
    obj = (v >= lvl);
    if (pos_z >= 1 && pos_x + 1 < rs && pos_y + 1 < cs) begin
      base = prev_bits[pos_y][pos_x];
      f.x = X_W'(pos_x);
      f.y = Y_W'(pos_y);
      f.z = Z_W'(pos_z - 1);
      f.base_in = base;
      f.tail = 1'b0;
      if (prev_bits[pos_y][pos_x + 1] != base) begin
        f.dir = AXIS_X;
        found.push_back(f);
      end
      if (prev_bits[pos_y + 1][pos_x] != base) begin
        f.dir = AXIS_Y;
        found.push_back(f);
      end
      if (obj != base) begin
        f.dir = AXIS_Z;
        found.push_back(f);
      end
      if (found.size() > 0) found[found.size() - 1].tail = 1'b1;
      foreach (found[i]) faces_due.push_back(found[i]);
    end
    cur_bits[pos_y][pos_x] = obj;
    next_pos(rs, cs, ds, pos_x, pos_y, pos_z, slice_end);
    // only the active region is ever read back
    if (slice_end) begin
      for (int yy = 0; yy < cs; yy++)
        for (int xx = 0; xx < rs; xx++)
          prev_bits[yy][xx] = cur_bits[yy][xx];
    end
  endfunction

  // voxels left until the position counters wrap back to the volume origin
  function automatic int unsigned voxels_to_wrap();
    int unsigned rs, cs, ds;
    int unsigned x = pos_x;
    int unsigned y = pos_y;
    int unsigned z = pos_z;
    int unsigned n = 0;
    bit          slice_end;
    eff_sizes(rs, cs, ds);
    do begin
      next_pos(rs, cs, ds, x, y, z, slice_end);
      n++;
    end while (x != 0 || y != 0 || z != 0);
    return n;
  endfunction

  function automatic logic [VOX_W-1:0] pick_voxel();
    int lvl, t;
    lvl = (lvl_reg == 0) ? 1 : int'(lvl_reg);
    if ($urandom_range(0, 2) == 0) return VOX_W'($urandom_range(0, 255));
    // mostly straddle the threshold so faces are frequent
    t = lvl + int'($urandom_range(0, 3)) - 2;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return VOX_W'(t);
  endfunction

  function automatic logic [31:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd255;
    return $urandom_range(1, 254);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_THRESHOLD:   lvl_reg = val[VOX_W-1:0];
      REG_ROW_SIZE:    row_reg = val[ROW_W-1:0];
      REG_COL_SIZE:    col_reg = val[ROW_W-1:0];
      REG_SLICE_COUNT: slc_reg = val[SLC_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_volume(logic [31:0] lvl, logic [31:0] rs, logic [31:0] cs,
                            logic [31:0] ds);
    reg_write(REG_THRESHOLD, lvl);
    reg_write(REG_ROW_SIZE, rs);
    reg_write(REG_COL_SIZE, cs);
    reg_write(REG_SLICE_COUNT, ds);
  endtask

  task automatic send_voxels(int unsigned n);
    repeat (n) voxel_feed.push_back(pick_voxel());
  endtask

  // drained: nothing queued, nothing offered, no face outstanding
  task automatic wait_idle();
    while (voxel_feed.size() != 0 || voxel_valid_i || faces_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // voxel driver
  always @(negedge clk_i) begin
    if (rst_ni && (!voxel_valid_i || voxel_taken)) begin
      if (gap_left > 0) begin
        voxel_valid_i <= 1'b0;
        gap_left--;
      end else if (voxel_feed.size() > 0) begin
        voxel_valid_i <= 1'b1;
        voxel_i <= voxel_feed.pop_front();
        gap_left = pick_gap();
      end else begin
        voxel_valid_i <= 1'b0;
      end
    end
  end

  // face receiver back-pressure
  always @(negedge clk_i) begin
    bit hold;
    hold = 1'b0;
    if (hold_left > 0) begin
      hold = 1'b1;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      hold = 1'b1;
    end else if (stall_left > 0) begin
      hold = 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                               : $urandom_range(0, 2);
      hold = 1'b1;
    end
    face_stall_i <= hold;
  end

  // request monitor: predict on accepted voxels, check accepted faces
  always @(posedge clk_i) begin
    face_t got, want;
    voxel_taken = rst_ni && voxel_valid_i && (voxel_stall_o === 1'b0);
    if (voxel_taken) extract_faces(voxel_i);
    if (rst_ni && face_valid_o === 1'b1 && face_stall_i == 1'b0) begin
      got.x = face_x_o;
      got.y = face_y_o;
      got.z = face_z_o;
      got.dir = axis_e'(axis_o);
      got.base_in = base_inside_o;
      got.tail = last_o;
      if (faces_due.size() == 0) begin
        bad_faces++;
        if (bad_faces <= MAX_REPORTS)
          $display("unexpected face: x=%0d y=%0d z=%0d axis=%0d base=%0d last=%0d",
                   got.x, got.y, got.z, got.dir, got.base_in, got.tail);
      end else begin
        want = faces_due.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.dir !== want.dir || got.base_in !== want.base_in ||
            got.tail !== want.tail) begin
          bad_faces++;
          if (bad_faces <= MAX_REPORTS) begin
            $display("face mismatch: exp x=%0d y=%0d z=%0d axis=%0d base=%0d last=%0d,",
                     want.x, want.y, want.z, want.dir, want.base_in, want.tail);
            $display("               got x=%0d y=%0d z=%0d axis=%0d base=%0d last=%0d",
                     got.x, got.y, got.z, got.dir, got.base_in, got.tail);
          end
        end
      end
    end
  end

  // watchdog and idle-pattern switching
  always @(posedge clk_i) begin
    calm_cnt++;
    if (calm_cnt >= 250) begin
      calm_cnt = 0;
      calm = ($urandom_range(0, 3) == 0);
    end
    if (rst_ni && !(voxel_valid_i && voxel_stall_o === 1'b0) &&
        !(face_valid_o === 1'b1 && !face_stall_i))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[voxel_boundary_face_extract_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [VOX_W-1:0] warm_up [18];
    logic [VOX_W-1:0] top_level [8];
    int unsigned      random_sent, n;
    warm_up = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0,
                8'd0, 8'd255, 8'd7, 8'd0, 8'd1, 8'd200, 8'd3, 8'd0, 8'd128};
    top_level = '{8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3x2, zero threshold acting as one: full three-face voxels of both orientations
    set_volume(32'd0, 32'd3, 32'd3, 32'd2);
    foreach (warm_up[i]) voxel_feed.push_back(warm_up[i]);
    wait_idle();

    // highest threshold on the smallest volume
    set_volume(32'd255, 32'd2, 32'd2, 32'd2);
    foreach (top_level[i]) voxel_feed.push_back(top_level[i]);
    wait_idle();

    // shrink rows and columns mid-slice; counters sit on the new last index
    set_volume(pick_level(), 32'd6, 32'd5, 32'd3);
    send_voxels(8);
    wait_idle();
    reg_write(REG_ROW_SIZE, 32'd3);
    reg_write(REG_COL_SIZE, 32'd2);
    send_voxels(voxels_to_wrap());
    wait_idle();

    // sizes clamp from below and above; slice count cut below z mid-volume, new threshold too
    set_volume(pick_level(), 32'd0, 32'd1, 32'd2047);
    send_voxels(12);
    wait_idle();
    reg_write(REG_SLICE_COUNT, 32'd2);
    reg_write(REG_THRESHOLD, pick_level());
    send_voxels(voxels_to_wrap());
    wait_idle();

    // sender pauses after the first slice; receiver then holds off through the second
    set_volume(pick_level(), 32'd5, 32'd5, 32'd3);
    send_voxels(25);
    wait_idle();
    hold_req = 1'b1;
    send_voxels(voxels_to_wrap());
    wait_idle();

    // random small volumes, some cut short and resumed under a new threshold
    random_sent = 0;
    while (random_sent < RANDOM_VOXELS) begin
      if (pos_x == 0 && pos_y == 0 && pos_z == 0)
        set_volume(pick_level(), $urandom_range(0, 5), $urandom_range(0, 5),
                   $urandom_range(1, 3));
      else
        reg_write(REG_THRESHOLD, pick_level());
      n = voxels_to_wrap();
      if (n > 1 && $urandom_range(0, 2) == 0) n = $urandom_range(1, n - 1);
      send_voxels(n);
      random_sent += n;
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (faces_due.size() != 0) begin
      $display("%0d expected faces never came out", faces_due.size());
      bad_faces += faces_due.size();
    end
    if (bad_faces == 0)
      $display("[voxel_boundary_face_extract_top] OK");
    else
      $display("[voxel_boundary_face_extract_top] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vbfe_pkg.sv
hdl/vbfe_front.sv
hdl/vbfe_queue.sv
hdl/vbfe_back.sv
hdl/voxel_boundary_face_extract_top.sv
bench/tb_voxel_boundary_face_extract_top.sv
